>>> hdl/sdvc_pkg.sv
// ----------------------------------------------------------------------------
// sdvc_pkg
// Shared types and constants of the sorted distinct value counter.
// ----------------------------------------------------------------------------
package sdvc_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 20;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_LOOK  = 2'd1;
	localparam logic [1:0] KIND_DUMP  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_HIT,
		EM_HIT_ADD,
		EM_MISS,
		EM_OVF,
		EM_NEW,
		EM_DUMP,
		EM_EMPTY
	} em_t;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic idx_dec;
		logic idx_used;
		logic pos_ld;
		logic rd_prev;
		logic wr_shift;
		logic wr_new;
		logic wr_inc;
		logic used_clr;
		em_t  emit;
	} cmd_t;

	typedef struct packed {
		logic idx_lt_used;
		logic idx_gt_pos;
		logic idx_last;
		logic key_lt;
		logic key_eq;
		logic full;
		logic empty;
	} stat_t;

endpackage

>>> hdl/sdvc_ctrl.sv
// ----------------------------------------------------------------------------
// sdvc_ctrl
// Sequencer for scan, shift-insert, dump and clear over the table memory.
// ----------------------------------------------------------------------------
module sdvc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     kind,
	input  sdvc_pkg::stat_t st,
	output sdvc_pkg::cmd_t  cmd,
	output logic           busy
);
	import sdvc_pkg::*;

	typedef enum logic [2:0] {
		IDLE, S_RD, S_CMP, SH, SH_WR, D_RD, D_EM
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] kind_q;

	assign busy = (state_q != IDLE);

	always_comb begin
		cmd     = '0;
		cmd.emit = EM_NONE;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					case (kind)
						KIND_CLEAR: cmd.used_clr = 1'b1;
						KIND_DUMP: begin
							if (st.empty) cmd.emit = EM_EMPTY;
							else state_d = D_RD;
						end
						default: state_d = S_RD;
					endcase
				end
			end
			S_RD: begin
				if (st.idx_lt_used) begin
					state_d = S_CMP;
				end else if (kind_q == KIND_LOOK) begin
					cmd.emit = EM_MISS;
					state_d  = IDLE;
				end else if (st.full) begin
					cmd.emit = EM_OVF;
					state_d  = IDLE;
				end else begin
					cmd.pos_ld   = 1'b1;
					cmd.idx_used = 1'b1;
					state_d      = SH;
				end
			end
			S_CMP: begin
				if (st.key_lt) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end else if (st.key_eq) begin
					if (kind_q == KIND_ADD) begin
						cmd.wr_inc = 1'b1;
						cmd.emit   = EM_HIT_ADD;
					end else begin
						cmd.emit = EM_HIT;
					end
					state_d = IDLE;
				end else if (kind_q == KIND_LOOK) begin
					cmd.emit = EM_MISS;
					state_d  = IDLE;
				end else if (st.full) begin
					cmd.emit = EM_OVF;
					state_d  = IDLE;
				end else begin
					cmd.pos_ld   = 1'b1;
					cmd.idx_used = 1'b1;
					state_d      = SH;
				end
			end
			SH: begin
				if (st.idx_gt_pos) begin
					cmd.rd_prev = 1'b1;
					state_d     = SH_WR;
				end else begin
					cmd.wr_new = 1'b1;
					cmd.emit   = EM_NEW;
					state_d    = IDLE;
				end
			end
			SH_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dec  = 1'b1;
				state_d      = SH;
			end
			D_RD: state_d = D_EM;
			D_EM: begin
				cmd.emit    = EM_DUMP;
				cmd.idx_inc = 1'b1;
				state_d     = st.idx_last ? IDLE : D_RD;
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			kind_q  <= KIND_ADD;
		end else begin
			state_q <= state_d;
			if (cmd.load) kind_q <= kind;
		end
	end

endmodule

>>> hdl/sdvc_dp.sv
// ----------------------------------------------------------------------------
// sdvc_dp
// Table memory, index and position registers, compare and result registers.
// ----------------------------------------------------------------------------
module sdvc_dp #(
	parameter int CAPACITY    = sdvc_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = sdvc_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = sdvc_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       sample_value,
	input  sdvc_pkg::cmd_t    cmd,
	output sdvc_pkg::stat_t   st,
	output logic              strobe,
	output logic [5:0]        entry_index,
	output logic [31:0]       entry_value,
	output logic [19:0]       entry_count,
	output logic              found,
	output logic              was_new,
	output logic              table_overflow,
	output logic [6:0]        distinct_total,
	output logic [31:0]       most_frequent_value,
	output logic              last
);
	import sdvc_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int UW = $clog2(CAPACITY + 1);
	localparam int VW = VALUE_WIDTH;
	localparam int CW = COUNT_WIDTH;

	logic [VW-1:0] keys_mem [CAPACITY];
	logic [CW-1:0] cnt_mem  [CAPACITY];

	logic [VW-1:0] key_q, rkey_q, best_val_q, best_val_d;
	logic [CW-1:0] rcnt_q, best_cnt_q, cnt_sat;
	logic [UW-1:0] used_q, idx_q, pos_q, idx_m1;
	logic [IW-1:0] raddr;
	logic [VW+31:0] ext_in;
	logic [VW+31:0] ext_out;
	logic [VW+31:0] ext_mfv;
	logic [CW+19:0] ext_cnt;
	logic [UW+5:0]  ext_idx;
	logic [UW+6:0]  ext_used;
	logic [UW-1:0] used_new;

	assign ext_in   = {{VW{sample_value[31]}}, sample_value};
	assign idx_m1   = idx_q - UW'(1);
	assign raddr    = cmd.rd_prev ? idx_m1[IW-1:0] : idx_q[IW-1:0];
	assign cnt_sat  = (rcnt_q == {CW{1'b1}}) ? rcnt_q : rcnt_q + CW'(1);
	assign used_new = used_q + UW'(1);

	assign st.idx_lt_used = (idx_q < used_q);
	assign st.idx_gt_pos  = (idx_q > pos_q);
	assign st.idx_last    = ((idx_q + UW'(1)) == used_q);
	assign st.key_lt      = ($signed(rkey_q) < $signed(key_q));
	assign st.key_eq      = (rkey_q == key_q);
	assign st.full        = (used_q == UW'(CAPACITY));
	assign st.empty       = (used_q == '0);

	assign best_val_d = ((idx_q == '0) || (rcnt_q > best_cnt_q)) ? rkey_q : best_val_q;

	always_ff @(posedge clk) begin
		rkey_q <= keys_mem[raddr];
		rcnt_q <= cnt_mem[raddr];
		if (cmd.wr_shift) begin
			keys_mem[idx_q[IW-1:0]] <= rkey_q;
			cnt_mem[idx_q[IW-1:0]]  <= rcnt_q;
		end else if (cmd.wr_new) begin
			keys_mem[idx_q[IW-1:0]] <= key_q;
			cnt_mem[idx_q[IW-1:0]]  <= CW'(1);
		end else if (cmd.wr_inc) begin
			cnt_mem[idx_q[IW-1:0]] <= cnt_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) key_q <= ext_in[VW-1:0];
		if (cmd.pos_ld) pos_q <= idx_q;
		if (cmd.emit == EM_DUMP) begin
			best_val_q <= best_val_d;
			best_cnt_q <= ((idx_q == '0) || (rcnt_q > best_cnt_q)) ? rcnt_q : best_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.used_clr) used_q <= '0;
			else if (cmd.wr_new) used_q <= used_new;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_used) idx_q <= used_q;
			else if (cmd.idx_inc) idx_q <= idx_q + UW'(1);
			else if (cmd.idx_dec) idx_q <= idx_m1;
		end
	end

	logic [VW-1:0] o_val, o_mfv;
	logic [CW-1:0] o_cnt;
	logic [UW-1:0] o_idx, o_used;
	logic          o_fnd, o_new, o_ovf, o_last;

	always_comb begin
		o_val  = key_q;
		o_mfv  = '0;
		o_cnt  = '0;
		o_idx  = '0;
		o_used = used_q;
		o_fnd  = 1'b0;
		o_new  = 1'b0;
		o_ovf  = 1'b0;
		o_last = 1'b1;
		case (cmd.emit)
			EM_HIT: begin
				o_idx = idx_q;
				o_cnt = rcnt_q;
				o_fnd = 1'b1;
			end
			EM_HIT_ADD: begin
				o_idx = idx_q;
				o_cnt = cnt_sat;
				o_fnd = 1'b1;
			end
			EM_OVF: o_ovf = 1'b1;
			EM_NEW: begin
				o_idx  = idx_q;
				o_cnt  = CW'(1);
				o_new  = 1'b1;
				o_used = used_new;
			end
			EM_DUMP: begin
				o_idx  = idx_q;
				o_val  = rkey_q;
				o_cnt  = rcnt_q;
				o_last = st.idx_last;
				o_mfv  = st.idx_last ? best_val_d : '0;
			end
			EM_EMPTY: o_val = '0;
			default: ;
		endcase
	end

	assign ext_out  = {32'd0, o_val};
	assign ext_mfv  = {32'd0, o_mfv};
	assign ext_cnt  = {20'd0, o_cnt};
	assign ext_idx  = {6'd0, o_idx};
	assign ext_used = {7'd0, o_used};

	always_ff @(posedge clk) begin
		entry_index         <= ext_idx[5:0];
		entry_value         <= ext_out[31:0];
		entry_count         <= ext_cnt[19:0];
		found               <= o_fnd;
		was_new             <= o_new;
		table_overflow      <= o_ovf;
		distinct_total      <= ext_used[6:0];
		most_frequent_value <= ext_mfv[31:0];
		last                <= o_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= (cmd.emit != EM_NONE);
	end

endmodule

>>> hdl/sorted_distinct_value_counter_unit.sv
// ----------------------------------------------------------------------------
// sorted_distinct_value_counter_unit
// Sorted table of distinct values with saturating occurrence counts.
// ----------------------------------------------------------------------------
// Usage: drive kind and sample_value with start; the item is taken on a
// clock edge where start is high and busy is low. Clear takes effect at
// once and returns nothing. Results appear for one cycle with strobe high;
// last marks the final result of an item. The receiver cannot stall.
// Steps of each item:
//   lookup, add hit: linear scan from entry 0, then a registered result.
//   add of a new value: scan, then entries are shifted up
//   one at a time through the table memory before the new one is written.
//   dump: one entry at a time; an empty table gives a single result.
// A new item is taken once busy falls. Reset empties the table; the
// memory itself is not swept since only entries below the fill count
// are read.
// ----------------------------------------------------------------------------
module sorted_distinct_value_counter_unit #(
	parameter int CAPACITY    = sdvc_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = sdvc_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = sdvc_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] sample_value,
	output logic        strobe,
	output logic [5:0]  entry_index,
	output logic [31:0] entry_value,
	output logic [19:0] entry_count,
	output logic        found,
	output logic        was_new,
	output logic        table_overflow,
	output logic [6:0]  distinct_total,
	output logic [31:0] most_frequent_value,
	output logic        last
);
	import sdvc_pkg::*;

	cmd_t  cmd;
	stat_t st;

	sdvc_ctrl u_ctrl (
		.clk, .arst_n, .start, .kind, .st, .cmd, .busy
	);

	sdvc_dp #(
		.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk, .arst_n, .sample_value, .cmd, .st, .strobe,
		.entry_index, .entry_value, .entry_count, .found, .was_new,
		.table_overflow, .distinct_total, .most_frequent_value, .last
	);

endmodule

>>> hdl/sdvc_checker.sv
// ----------------------------------------------------------------------------
// sdvc_checker
// Port-level checks of the sorted distinct value counter.
// ----------------------------------------------------------------------------
module sdvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  kind,
	input logic        strobe,
	input logic [19:0] entry_count,
	input logic        found,
	input logic        was_new,
	input logic        table_overflow
);
	import sdvc_pkg::*;

	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_ADD |=> busy)
		else $error("add item did not start work");

	a_new_excl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && was_new |-> !found && !table_overflow && entry_count == 20'd1)
		else $error("new entry flags inconsistent");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && table_overflow |-> !found && entry_count == 20'd0)
		else $error("overflow result inconsistent");

	a_found_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && found |-> entry_count != 20'd0)
		else $error("matched entry with zero count");

endmodule

bind sorted_distinct_value_counter_unit sdvc_checker u_sdvc_checker (.*);

>>> tb/sorted_distinct_value_counter_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_distinct_value_counter_unit_tb
// Drives add, lookup, dump and clear items with random gaps, including table
// fill and overflow, and checks every result against a behavioral table.
// ----------------------------------------------------------------------------
module sorted_distinct_value_counter_unit_tb;
	import sdvc_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic [19:0] CNT_MAX = 20'hFFFFF;

	typedef struct {
		logic [5:0]  idx;
		logic [31:0] val;
		logic [19:0] cnt;
		logic        fnd;
		logic        nw;
		logic        ovf;
		logic [6:0]  tot;
		logic [31:0] mfv;
		logic        lst;
	} entry_res_t;

	class histogram_board;
		logic signed [31:0] keys[CAP];
		logic [19:0]        counts[CAP];
		int                 used;
		entry_res_t         pending[$];
		int                 errors;

		function void note_item(logic [1:0] k, logic signed [31:0] v);
			entry_res_t r;
			int p;
			int i;
			logic signed [31:0] best_v;
			logic [19:0] best_c;
			if (k == KIND_CLEAR) begin
				used = 0;
				return;
			end
			if (k == KIND_DUMP) begin
				if (used == 0) begin
					r = '{6'd0, 32'd0, 20'd0, 1'b0, 1'b0, 1'b0, 7'd0, 32'd0, 1'b1};
					pending.push_back(r);
					return;
				end
				best_v = keys[0];
				best_c = counts[0];
				for (i = 1; i < used; i++)
					if (counts[i] > best_c) begin
						best_c = counts[i];
						best_v = keys[i];
					end
				for (i = 0; i < used; i++) begin
					r = '{i[5:0], keys[i], counts[i], 1'b0, 1'b0, 1'b0, used[6:0],
						(i == used - 1) ? best_v : 32'd0, i == used - 1};
					pending.push_back(r);
				end
				return;
			end
			p = 0;
			while (p < used && keys[p] < v)
				p++;
			r = '{6'd0, v, 20'd0, 1'b0, 1'b0, 1'b0, 7'd0, 32'd0, 1'b1};
			if (p < used && keys[p] == v) begin
				if (k == KIND_ADD && counts[p] != CNT_MAX)
					counts[p]++;
				r.idx = p[5:0];
				r.cnt = counts[p];
				r.fnd = 1'b1;
			end else if (k == KIND_ADD) begin
				if (used >= CAP)
					r.ovf = 1'b1;
				else begin
					for (i = used; i > p; i--) begin
						keys[i] = keys[i - 1];
						counts[i] = counts[i - 1];
					end
					keys[p] = v;
					counts[p] = 20'd1;
					used++;
					r.idx = p[5:0];
					r.cnt = 20'd1;
					r.nw = 1'b1;
				end
			end
			r.tot = used[6:0];
			pending.push_back(r);
		endfunction

		function void check_result(entry_res_t a);
			entry_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result idx=%0d val=%0h", a.idx, a.val);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.idx != e.idx) begin $error("entry_index exp %0d got %0d", e.idx, a.idx); errors++; end
			if (a.val != e.val) begin $error("entry_value exp %0h got %0h", e.val, a.val); errors++; end
			if (a.cnt != e.cnt) begin $error("entry_count exp %0d got %0d", e.cnt, a.cnt); errors++; end
			if (a.fnd != e.fnd) begin $error("found exp %0d got %0d", e.fnd, a.fnd); errors++; end
			if (a.nw != e.nw) begin $error("was_new exp %0d got %0d", e.nw, a.nw); errors++; end
			if (a.ovf != e.ovf) begin $error("table_overflow exp %0d got %0d", e.ovf, a.ovf); errors++; end
			if (a.tot != e.tot) begin $error("distinct_total exp %0d got %0d", e.tot, a.tot); errors++; end
			if (a.mfv != e.mfv) begin
				$error("most_frequent_value exp %0h got %0h", e.mfv, a.mfv);
				errors++;
			end
			if (a.lst != e.lst) begin $error("last exp %0d got %0d", e.lst, a.lst); errors++; end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [31:0] sample_value;
	logic        strobe;
	logic [5:0]  entry_index;
	logic [31:0] entry_value;
	logic [19:0] entry_count;
	logic        found;
	logic        was_new;
	logic        table_overflow;
	logic [6:0]  distinct_total;
	logic [31:0] most_frequent_value;
	logic        last;

	histogram_board board;
	logic signed [31:0] pool[16];

	sorted_distinct_value_counter_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .sample_value(sample_value), .strobe(strobe),
		.entry_index(entry_index), .entry_value(entry_value),
		.entry_count(entry_count), .found(found), .was_new(was_new),
		.table_overflow(table_overflow), .distinct_total(distinct_total),
		.most_frequent_value(most_frequent_value), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		entry_res_t a;
		if (arst_n && strobe) begin
			a = '{entry_index, entry_value, entry_count, found, was_new,
				table_overflow, distinct_total, most_frequent_value, last};
			board.check_result(a);
		end
	end

	// issue one item, hold until taken, then drop start for a random gap (none if the gap is zero)
	task automatic send_item(logic [1:0] k, logic [31:0] v);
		int gap;
		start <= 1'b1;
		kind <= k;
		sample_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_item(k, v);
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			kind <= 2'($urandom);
			sample_value <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			default: return pool[$urandom_range(0, 15)];
		endcase
	endfunction

	initial begin
		int i;
		int r;
		logic [1:0] k;
		board = new();
		board.used = 0;
		board.errors = 0;
		start = 1'b0;
		kind = KIND_ADD;
		sample_value = 32'd0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < 16; i++)
			pool[i] = $urandom;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;

		send_item(KIND_DUMP, 32'd0);
		send_item(KIND_LOOK, 32'h1234_0000);
		send_item(KIND_ADD, 32'h7FFF_FFFF);
		send_item(KIND_ADD, 32'h8000_0000);
		send_item(KIND_ADD, 32'd0);
		send_item(KIND_ADD, 32'hFFFF_FFFF);
		send_item(KIND_ADD, 32'h8000_0000);
		send_item(KIND_ADD, 32'h7FFF_FFFF);
		send_item(KIND_ADD, 32'h7FFF_FFFF);
		send_item(KIND_LOOK, 32'h7FFF_FFFF);
		send_item(KIND_LOOK, 32'h0001_0000);
		send_item(KIND_DUMP, 32'hFFFF_FFFF);
		send_item(KIND_CLEAR, 32'd0);
		send_item(KIND_DUMP, 32'd0);
		drain();

		// fill the table, then overflow it
		for (i = 0; i < CAP; i++)
			send_item(KIND_ADD, (i * 32'h0003_1000) ^ 32'h8000_0000);
		send_item(KIND_ADD, 32'h0000_0123);
		send_item(KIND_ADD, 32'h8000_0000);
		send_item(KIND_DUMP, 32'd0);
		drain();
		send_item(KIND_CLEAR, 32'd0);

		for (i = 0; i < 70; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				k = KIND_ADD;
			else if (r < 85)
				k = KIND_LOOK;
			else if (r < 95)
				k = KIND_DUMP;
			else
				k = KIND_CLEAR;
			send_item(k, pick_value());
			if (i == 35)
				drain();
		end
		send_item(KIND_DUMP, 32'd0);
		drain();
		repeat (20) @(posedge clk);

		if (board.errors == 0 && board.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

>>> files.f
hdl/sdvc_pkg.sv
hdl/sdvc_ctrl.sv
hdl/sdvc_dp.sv
hdl/sorted_distinct_value_counter_unit.sv
hdl/sdvc_checker.sv
tb/sorted_distinct_value_counter_unit_tb.sv
